>>> hdl/mdps_pkg.sv
`timescale 1ns / 1ps

package mdps_pkg;

   localparam int FRAC_BITS = 24;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int EPS       = (ONE + 500000) / 1000000;
   localparam int WMIN      = (ONE + 50000) / 100000;
   localparam int EPS_W     = $clog2(EPS + 1);
   localparam int SQ_W      = 2 * EPS_W + 1;
   localparam int PRESS_MUL = 100 * 65536;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_MASS        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_ANGLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NIB_WIDTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_RANGE = 3'd6;

   localparam logic [16:0]        RST_MASS        = 17'd32768;
   localparam logic [16:0]        RST_DRAG        = 17'd9830;
   localparam logic               RST_FIXED_ANGLE = 1'b1;
   localparam logic signed [17:0] RST_ANGLE_X     = 18'sd39322;
   localparam logic signed [17:0] RST_ANGLE_Y     = 18'sd13107;
   localparam logic [23:0]        RST_NIB_WIDTH   = 24'd98304;
   localparam logic [16:0]        RST_WIDTH_RANGE = 17'd3277;

   localparam int DIV_NUM_W  = 50;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
   localparam int SQRT_IN_W  = 64;
   localparam int SQRT_OUT_W = 32;
   localparam int SQRT_CNT_W = $clog2(SQRT_OUT_W);
   localparam int MUL_A_W    = 38;
   localparam int MUL_B_W    = 33;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } mdps_div_req_type;

   typedef struct packed {
      logic                 done;
      logic                 busy;
      logic [DIV_NUM_W-1:0] quotient;
   } mdps_div_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [SQRT_IN_W-1:0] radicand;
   } mdps_sqrt_req_type;

   typedef struct packed {
      logic                  done;
      logic [SQRT_OUT_W-1:0] root;
   } mdps_sqrt_rsp_type;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic is_small(input logic signed [32:0] x,
                                     input logic signed [32:0] y);
      logic [32:0]     mx;
      logic [32:0]     my;
      logic [SQ_W-1:0] s;
      mx = mag33(x);
      my = mag33(y);
      s  = SQ_W'(mx[EPS_W-1:0] * mx[EPS_W-1:0]) + SQ_W'(my[EPS_W-1:0] * my[EPS_W-1:0]);
      return (mx < 33'(EPS)) && (my < 33'(EPS)) && (s < SQ_W'(EPS * EPS));
   endfunction

   function automatic logic signed [MUL_P_W-1:0] round16(input logic signed [MUL_P_W-1:0] v);
      logic [MUL_P_W-1:0] m;
      m = v[MUL_P_W-1] ? MUL_P_W'(-v) : MUL_P_W'(v);
      m = (m + MUL_P_W'(32768)) >> 16;
      return v[MUL_P_W-1] ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -72'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [16:0] sat16(input logic [16:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
   endfunction

   function automatic logic signed [DIV_NUM_W:0] apply_sign(input logic [DIV_NUM_W-1:0] q,
                                                            input logic neg);
      logic signed [DIV_NUM_W:0] s;
      s = signed'({1'b0, q});
      return neg ? -s : s;
   endfunction

   function automatic logic signed [17:0] clamp_dir(input logic [DIV_NUM_W-1:0] q,
                                                    input logic neg);
      logic [16:0] c;
      c = (q > DIV_NUM_W'(65536)) ? 17'd65536 : q[16:0];
      return neg ? -signed'({1'b0, c}) : signed'({1'b0, c});
   endfunction

endpackage

>>> hdl/mdps_if.sv
`timescale 1ns / 1ps

interface mdps_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] sample_x;
   logic signed [31:0] sample_y;

   modport source (output valid, output operation, output sample_x, output sample_y,
                   input ready);
   modport sink (input valid, input operation, input sample_x, input sample_y,
                 output ready);
endinterface

interface mdps_rsp_if;
   logic               valid;
   logic               ready;
   logic               moved;
   logic signed [31:0] pen_x;
   logic signed [31:0] pen_y;
   logic signed [31:0] nib_dx;
   logic signed [31:0] nib_dy;
   logic [16:0]        pressure;

   modport source (output valid, output moved, output pen_x, output pen_y,
                   output nib_dx, output nib_dy, output pressure, input ready);
   modport sink (input valid, input moved, input pen_x, input pen_y,
                 input nib_dx, input nib_dy, input pressure, output ready);
endinterface

>>> hdl/mdps_mul.sv
`timescale 1ns / 1ps

module mdps_mul (
   input  logic                                 clock,
   input  logic signed [mdps_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [mdps_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [mdps_pkg::MUL_P_W-1:0]  product
);

   logic signed [mdps_pkg::MUL_P_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign product = product_ff;

endmodule

>>> hdl/mdps_div.sv
`timescale 1ns / 1ps

module mdps_div (
   input  logic                       clock,
   input  logic                       reset,
   input  mdps_pkg::mdps_div_req_type div_req,
   output mdps_pkg::mdps_div_rsp_type div_rsp
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [mdps_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [mdps_pkg::DIV_NUM_W-1:0]     quo_ff;
   logic [mdps_pkg::DIV_DEN_W-1:0]     rem_ff;
   logic [mdps_pkg::DIV_DEN_W-1:0]     den_ff;
   logic [mdps_pkg::DIV_DEN_W:0]       trial;
   logic [mdps_pkg::DIV_DEN_W:0]       diff;
   logic                               ge;

   assign trial = {rem_ff, quo_ff[mdps_pkg::DIV_NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == mdps_pkg::DIV_CNT_W'(mdps_pkg::DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         den_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[mdps_pkg::DIV_DEN_W-1:0] : trial[mdps_pkg::DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[mdps_pkg::DIV_NUM_W-2:0], ge};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> hdl/mdps_sqrt.sv
`timescale 1ns / 1ps

module mdps_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  mdps_pkg::mdps_sqrt_req_type sqrt_req,
   output mdps_pkg::mdps_sqrt_rsp_type sqrt_rsp
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [mdps_pkg::SQRT_CNT_W-1:0]    cnt_ff;
   logic [mdps_pkg::SQRT_IN_W-1:0]     rad_ff;
   logic [33:0]                        rem_ff;
   logic [mdps_pkg::SQRT_OUT_W-1:0]    root_ff;
   logic [35:0]                        rem_t;
   logic [35:0]                        trial;
   logic                               ge;

   assign rem_t = {rem_ff, rad_ff[mdps_pkg::SQRT_IN_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign ge    = rem_t >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == mdps_pkg::SQRT_CNT_W'(mdps_pkg::SQRT_OUT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sqrt_req.start) begin
         rad_ff  <= sqrt_req.radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
         rad_ff  <= rad_ff << 2;
         root_ff <= {root_ff[mdps_pkg::SQRT_OUT_W-2:0], ge};
      end
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

>>> hdl/mass_drag_pointer_smoother_unit.sv
`timescale 1ns / 1ps

// mass and drag pointer smoother
// req_ch takes one beat per pointer sample: operation 0 places the pen at the
// sample and clears velocity, operation 1 pulls the pen toward the sample.
// rsp_ch gives one beat per request: moved flag, pen position after the step,
// nib offset and pressure (offset and pressure are zero when moved is 0).
// csr_wr_en/csr_index/csr_wr_data write the settings; the user must write them only
// while the unit is idle, and the unit itself does not enforce it.
// a start and a move with a tiny pull run no division; any other move runs two
// serial divisions of a 50-bit dividend, and one that passes the speed check
// adds a square root of a 64-bit radicand and, when the nib follows the velocity
// normal, two more divisions. one multiplier is shared by all the products.
// one request is in flight at a time; req_ch.ready is high only while the
// sequencer is idle, from the cycle after the result is loaded.
// reset (synchronous) clears pen position and velocity and loads the default
// settings. the result sits in an output register; a stalled receiver holds
// the beat and the next request is accepted meanwhile, its result waiting
// until the register frees up.
module mass_drag_pointer_smoother_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mdps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdps_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   mdps_req_if.sink                            req_ch,
   mdps_rsp_if.source                          rsp_ch
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_CHKF  = 5'd1;
   localparam logic [4:0] ST_DIVX  = 5'd2;
   localparam logic [4:0] ST_DIVY  = 5'd3;
   localparam logic [4:0] ST_CHKV  = 5'd4;
   localparam logic [4:0] ST_SQ1   = 5'd5;
   localparam logic [4:0] ST_SQ2   = 5'd6;
   localparam logic [4:0] ST_SQRT  = 5'd7;
   localparam logic [4:0] ST_NX    = 5'd8;
   localparam logic [4:0] ST_NY    = 5'd9;
   localparam logic [4:0] ST_WID   = 5'd10;
   localparam logic [4:0] ST_WID2  = 5'd11;
   localparam logic [4:0] ST_OFSX  = 5'd12;
   localparam logic [4:0] ST_OFSY  = 5'd13;
   localparam logic [4:0] ST_KEEP  = 5'd14;
   localparam logic [4:0] ST_KEEP2 = 5'd15;
   localparam logic [4:0] ST_VELX  = 5'd16;
   localparam logic [4:0] ST_VELY  = 5'd17;
   localparam logic [4:0] ST_POS   = 5'd18;
   localparam logic [4:0] ST_POS2  = 5'd19;
   localparam logic [4:0] ST_OUT   = 5'd20;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   logic [16:0]        mass_ff;
   logic [16:0]        drag_ff;
   logic               fixed_angle_ff;
   logic signed [17:0] angle_x_ff;
   logic signed [17:0] angle_y_ff;
   logic [23:0]        nib_width_ff;
   logic [16:0]        width_range_ff;

   logic signed [31:0] pen_x_ff;
   logic signed [31:0] pen_y_ff;
   logic signed [31:0] vel_x_ff;
   logic signed [31:0] vel_y_ff;
   logic signed [32:0] fx_ff;
   logic signed [32:0] fy_ff;
   logic [63:0]        sq_ff;
   logic [31:0]        spd_ff;
   logic signed [17:0] ax_ff;
   logic signed [17:0] ay_ff;
   logic [36:0]        wid_ff;
   logic [16:0]        keep_ff;
   logic [16:0]        press_ff;
   logic signed [31:0] dx_ff;
   logic signed [31:0] dy_ff;
   logic               moved_ff;
   logic               div_neg_ff;

   logic               rsp_valid_ff;
   logic               rsp_moved_ff;
   logic signed [31:0] rsp_pen_x_ff;
   logic signed [31:0] rsp_pen_y_ff;
   logic signed [31:0] rsp_dx_ff;
   logic signed [31:0] rsp_dy_ff;
   logic [16:0]        rsp_press_ff;

   logic                                 req_accept;
   logic                                 out_load;
   logic [23:0]                          mq;
   logic [33:0]                          range_u;
   logic signed [33:0]                   diff;
   logic signed [mdps_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [mdps_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [mdps_pkg::MUL_P_W-1:0]  mul_p;
   logic signed [mdps_pkg::MUL_P_W-1:0]  p_rnd;
   logic [55:0]                          press_raw;
   logic [33:0]                          keep_sub;
   logic signed [mdps_pkg::DIV_NUM_W:0]  acc;
   mdps_pkg::mdps_div_req_type           div_req;
   mdps_pkg::mdps_div_rsp_type           div_rsp;
   mdps_pkg::mdps_sqrt_req_type          sqrt_req;
   mdps_pkg::mdps_sqrt_rsp_type          sqrt_rsp;

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   assign mq        = 24'd65536 + 24'(8'd159 * mdps_pkg::sat16(mass_ff));
   assign range_u   = 34'(mdps_pkg::sat16(width_range_ff)) << (mdps_pkg::FRAC_BITS - 16);
   assign diff      = signed'(range_u) - signed'(34'(spd_ff));
   assign p_rnd     = mdps_pkg::round16(mul_p);
   assign press_raw = (mul_p[55:0] + 56'(mdps_pkg::ONE >> 1)) >> mdps_pkg::FRAC_BITS;
   assign keep_sub  = (mul_p[33:0] + 34'd65536) >> 17;
   assign acc       = mdps_pkg::apply_sign(div_rsp.quotient, div_neg_ff);

   // shared units
   mdps_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_p)
   );

   mdps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mdps_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff        <= mdps_pkg::RST_MASS;
         drag_ff        <= mdps_pkg::RST_DRAG;
         fixed_angle_ff <= mdps_pkg::RST_FIXED_ANGLE;
         angle_x_ff     <= mdps_pkg::RST_ANGLE_X;
         angle_y_ff     <= mdps_pkg::RST_ANGLE_Y;
         nib_width_ff   <= mdps_pkg::RST_NIB_WIDTH;
         width_range_ff <= mdps_pkg::RST_WIDTH_RANGE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mdps_pkg::CSR_MASS:        mass_ff        <= csr_wr_data[16:0];
            mdps_pkg::CSR_DRAG:        drag_ff        <= csr_wr_data[16:0];
            mdps_pkg::CSR_FIXED_ANGLE: fixed_angle_ff <= csr_wr_data[0];
            mdps_pkg::CSR_ANGLE_X:     angle_x_ff     <= signed'(csr_wr_data[17:0]);
            mdps_pkg::CSR_ANGLE_Y:     angle_y_ff     <= signed'(csr_wr_data[17:0]);
            mdps_pkg::CSR_NIB_WIDTH:   nib_width_ff   <= csr_wr_data;
            mdps_pkg::CSR_WIDTH_RANGE: width_range_ff <= csr_wr_data[16:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_ch.operation ? ST_CHKF : ST_OUT;
            end
         end
         ST_CHKF:  state_in = mdps_pkg::is_small(fx_ff, fy_ff) ? ST_OUT : ST_DIVX;
         ST_DIVX:  state_in = div_rsp.done ? ST_DIVY : ST_DIVX;
         ST_DIVY:  state_in = div_rsp.done ? ST_CHKV : ST_DIVY;
         ST_CHKV: begin
            state_in = mdps_pkg::is_small(33'(vel_x_ff), 33'(vel_y_ff)) ? ST_OUT : ST_SQ1;
         end
         ST_SQ1:   state_in = ST_SQ2;
         ST_SQ2:   state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               state_in = fixed_angle_ff ? ST_WID : ST_NX;
            end
         end
         ST_NX:    state_in = div_rsp.done ? ST_NY : ST_NX;
         ST_NY:    state_in = div_rsp.done ? ST_WID : ST_NY;
         ST_WID:   state_in = ST_WID2;
         ST_WID2:  state_in = ST_OFSX;
         ST_OFSX:  state_in = ST_OFSY;
         ST_OFSY:  state_in = ST_KEEP;
         ST_KEEP:  state_in = ST_KEEP2;
         ST_KEEP2: state_in = ST_VELX;
         ST_VELX:  state_in = ST_VELY;
         ST_VELY:  state_in = ST_POS;
         ST_POS:   state_in = ST_POS2;
         ST_POS2:  state_in = ST_OUT;
         ST_OUT:   state_in = out_load ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CHKV: begin
            mul_a = mdps_pkg::MUL_A_W'(vel_x_ff);
            mul_b = mdps_pkg::MUL_B_W'(vel_x_ff);
         end
         ST_SQ1: begin
            mul_a = mdps_pkg::MUL_A_W'(vel_y_ff);
            mul_b = mdps_pkg::MUL_B_W'(vel_y_ff);
         end
         ST_WID: begin
            mul_a = mdps_pkg::MUL_A_W'(diff);
            mul_b = signed'({9'd0, nib_width_ff});
         end
         ST_WID2: begin
            mul_a = signed'({6'd0, spd_ff});
            mul_b = mdps_pkg::MUL_B_W'(mdps_pkg::PRESS_MUL);
         end
         ST_OFSX: begin
            mul_a = signed'({1'b0, wid_ff});
            mul_b = mdps_pkg::MUL_B_W'(ax_ff);
         end
         ST_OFSY: begin
            mul_a = signed'({1'b0, wid_ff});
            mul_b = mdps_pkg::MUL_B_W'(ay_ff);
         end
         ST_KEEP: begin
            mul_a = signed'({21'd0, mdps_pkg::sat16(drag_ff)});
            mul_b = signed'({16'd0, mdps_pkg::sat16(drag_ff)});
         end
         ST_VELX: begin
            mul_a = mdps_pkg::MUL_A_W'(vel_x_ff);
            mul_b = signed'({16'd0, keep_ff});
         end
         ST_VELY: begin
            mul_a = mdps_pkg::MUL_A_W'(vel_y_ff);
            mul_b = signed'({16'd0, keep_ff});
         end
         default: begin
         end
      endcase
   end

   // divider and square root requests
   always_comb begin
      div_req  = '0;
      sqrt_req = '0;
      unique case (state_ff)
         ST_CHKF: begin
            div_req.start    = !mdps_pkg::is_small(fx_ff, fy_ff);
            div_req.dividend = (mdps_pkg::DIV_NUM_W'(mdps_pkg::mag33(fx_ff)) << 16)
                               + mdps_pkg::DIV_NUM_W'(mq[23:1]);
            div_req.divisor  = 32'(mq);
         end
         ST_DIVX: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = (mdps_pkg::DIV_NUM_W'(mdps_pkg::mag33(fy_ff)) << 16)
                               + mdps_pkg::DIV_NUM_W'(mq[23:1]);
            div_req.divisor  = 32'(mq);
         end
         ST_SQ2: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = sq_ff + mul_p[63:0];
         end
         ST_SQRT: begin
            div_req.start    = sqrt_rsp.done && !fixed_angle_ff;
            div_req.dividend = (mdps_pkg::DIV_NUM_W'(mdps_pkg::mag33(33'(vel_y_ff))) << 16)
                               + mdps_pkg::DIV_NUM_W'(sqrt_rsp.root[31:1]);
            div_req.divisor  = sqrt_rsp.root;
         end
         ST_NX: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = (mdps_pkg::DIV_NUM_W'(mdps_pkg::mag33(33'(vel_x_ff))) << 16)
                               + mdps_pkg::DIV_NUM_W'(spd_ff[31:1]);
            div_req.divisor  = spd_ff;
         end
         default: begin
         end
      endcase
   end

   // control and pen state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && !req_ch.operation) begin
                  pen_x_ff <= req_ch.sample_x;
                  pen_y_ff <= req_ch.sample_y;
                  vel_x_ff <= '0;
                  vel_y_ff <= '0;
               end
            end
            ST_DIVX: begin
               if (div_rsp.done) begin
                  vel_x_ff <= mdps_pkg::sat32(72'(vel_x_ff) + 72'(acc));
               end
            end
            ST_DIVY: begin
               if (div_rsp.done) begin
                  vel_y_ff <= mdps_pkg::sat32(72'(vel_y_ff) + 72'(acc));
               end
            end
            ST_VELY: vel_x_ff <= p_rnd[31:0];
            ST_POS:  vel_y_ff <= p_rnd[31:0];
            ST_POS2: begin
               pen_x_ff <= mdps_pkg::sat32(72'(pen_x_ff) + 72'(vel_x_ff));
               pen_y_ff <= mdps_pkg::sat32(72'(pen_y_ff) + 72'(vel_y_ff));
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            moved_ff <= 1'b0;
            fx_ff    <= 33'(req_ch.sample_x) - 33'(pen_x_ff);
            fy_ff    <= 33'(req_ch.sample_y) - 33'(pen_y_ff);
         end
         ST_CHKF:  div_neg_ff <= fx_ff[32];
         ST_DIVX: begin
            if (div_rsp.done) begin
               div_neg_ff <= fy_ff[32];
            end
         end
         ST_SQ1:   sq_ff <= mul_p[63:0];
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               spd_ff     <= sqrt_rsp.root;
               ax_ff      <= angle_x_ff;
               ay_ff      <= angle_y_ff;
               div_neg_ff <= !vel_y_ff[31];
            end
         end
         ST_NX: begin
            if (div_rsp.done) begin
               ax_ff      <= mdps_pkg::clamp_dir(div_rsp.quotient, div_neg_ff);
               div_neg_ff <= vel_x_ff[31];
            end
         end
         ST_NY: begin
            if (div_rsp.done) begin
               ay_ff <= mdps_pkg::clamp_dir(div_rsp.quotient, div_neg_ff);
            end
         end
         ST_WID2: begin
            wid_ff <= (p_rnd < mdps_pkg::MUL_P_W'(mdps_pkg::WMIN))
                      ? 37'(mdps_pkg::WMIN) : p_rnd[36:0];
         end
         ST_OFSX:  press_ff <= (press_raw > 56'd65536) ? 17'd65536 : press_raw[16:0];
         ST_OFSY:  dx_ff <= mdps_pkg::sat32(72'(p_rnd));
         ST_KEEP:  dy_ff <= mdps_pkg::sat32(72'(p_rnd));
         ST_KEEP2: keep_ff <= 17'd65536 - keep_sub[16:0];
         ST_POS2:  moved_ff <= 1'b1;
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_moved_ff <= moved_ff;
         rsp_pen_x_ff <= pen_x_ff;
         rsp_pen_y_ff <= pen_y_ff;
         rsp_dx_ff    <= moved_ff ? dx_ff : '0;
         rsp_dy_ff    <= moved_ff ? dy_ff : '0;
         rsp_press_ff <= moved_ff ? press_ff : '0;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.moved    = rsp_moved_ff;
   assign rsp_ch.pen_x    = rsp_pen_x_ff;
   assign rsp_ch.pen_y    = rsp_pen_y_ff;
   assign rsp_ch.nib_dx   = rsp_dx_ff;
   assign rsp_ch.nib_dy   = rsp_dy_ff;
   assign rsp_ch.pressure = rsp_press_ff;

   a_idle_beat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.moved |->
         rsp_ch.nib_dx == 32'sd0 && rsp_ch.nib_dy == 32'sd0 && rsp_ch.pressure == 17'd0)
      else $error("unmoved beat carries nib offset or pressure");

   a_pressure_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.pressure <= 17'd65536)
      else $error("pressure above one");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after a request beat");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam bit OP_START = 1'b0;
   localparam bit OP_MOVE  = 1'b1;
   localparam int SETTLE   = 400;

   typedef struct {
      bit     moved;
      longint pen_x;
      longint pen_y;
      longint nib_dx;
      longint nib_dy;
      longint pressure;
   } pen_beat_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [mdps_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mdps_pkg::CSR_DATA_W-1:0] csr_wr_data;

   mdps_req_if req_ch ();
   mdps_rsp_if rsp_ch ();

   mass_drag_pointer_smoother_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // shadow of the smoother state and settings
   longint       pos_x, pos_y, vel_x, vel_y;
   longint       mass_q, drag_q, fixed_dir, dir_x, dir_y, nib_w, w_range;
   pen_beat_type pen_expected[$];
   int           errors;
   int           samples_sent;
   int           beats_seen;
   int           moved_seen;
   bit           calm;
   bit           hold_req;
   int           hold_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("tb: FAIL");
      $finish;
   end

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint div_rnd(longint num, longint den);
      longint q;
      q = (mag(num) + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint sat_one(longint v);
      return v > 65536 ? 65536 : v;
   endfunction

   function automatic longint sext(longint v, int w);
      longint m;
      m = longint'(1) << (w - 1);
      v = v & ((m << 1) - 1);
      return (v ^ m) - m;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit below_eps(longint x, longint y);
      longint ax, ay;
      ax = mag(x);
      ay = mag(y);
      if (ax >= mdps_pkg::EPS || ay >= mdps_pkg::EPS) begin
         return 1'b0;
      end
      return ax * ax + ay * ay < longint'(mdps_pkg::EPS) * mdps_pkg::EPS;
   endfunction

   function automatic pen_beat_type smooth_step(bit op, longint sx, longint sy);
      pen_beat_type      r;
      longint            fx, fy, mq, ax, ay, wid, rng, ds, keep;
      longint unsigned   vx2, vy2, spd, press;
      r = '{default: 0};
      if (op == OP_START) begin
         pos_x = sx;
         pos_y = sy;
         vel_x = 0;
         vel_y = 0;
      end else begin
         fx = sx - pos_x;
         fy = sy - pos_y;
         if (!below_eps(fx, fy)) begin
            mq = 65536 + 159 * sat_one(mass_q);
            vel_x = sat32(vel_x + div_rnd(fx * 65536, mq));
            vel_y = sat32(vel_y + div_rnd(fy * 65536, mq));
            if (!below_eps(vel_x, vel_y)) begin
               vx2 = mag(vel_x);
               vy2 = mag(vel_y);
               spd = root_floor(vx2 * vx2 + vy2 * vy2);
               if (fixed_dir != 0) begin
                  ax = sext(dir_x, 18);
                  ay = sext(dir_y, 18);
               end else begin
                  ax = div_rnd(-vel_y * 65536, longint'(spd));
                  ay = div_rnd(vel_x * 65536, longint'(spd));
                  ax = ax > 65536 ? 65536 : (ax < -65536 ? -65536 : ax);
                  ay = ay > 65536 ? 65536 : (ay < -65536 ? -65536 : ay);
               end
               rng = sat_one(w_range) << (mdps_pkg::FRAC_BITS - 16);
               wid = div_rnd((rng - longint'(spd)) * nib_w, 65536);
               if (wid < mdps_pkg::WMIN) wid = mdps_pkg::WMIN;
               r.nib_dx = sat32(div_rnd(ax * wid, 65536));
               r.nib_dy = sat32(div_rnd(ay * wid, 65536));
               press = (spd * 100 * 65536 + (64'd1 << (mdps_pkg::FRAC_BITS - 1)))
                       >> mdps_pkg::FRAC_BITS;
               r.pressure = press > 65536 ? 65536 : longint'(press);
               ds = sat_one(drag_q);
               keep = 65536 - ((ds * ds + 65536) >> 17);
               vel_x = div_rnd(vel_x * keep, 65536);
               vel_y = div_rnd(vel_y * keep, 65536);
               pos_x = sat32(pos_x + vel_x);
               pos_y = sat32(pos_y + vel_y);
               r.moved = 1'b1;
            end
         end
      end
      r.pen_x = pos_x;
      r.pen_y = pos_y;
      return r;
   endfunction

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_beat();
         end
         if (hold_req) begin
            hold_cnt = 600;
            hold_req = 1'b0;
         end
         if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            rsp_ch.ready <= 1'b0;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= $urandom_range(0, 99) >= 35;
         end
      end
   end

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   task automatic check_beat();
      pen_beat_type e;
      beats_seen++;
      if (pen_expected.size() == 0) begin
         errors++;
         $display("%0t: unexpected beat, expected none, actual pen %0d %0d",
                  $time, rsp_ch.pen_x, rsp_ch.pen_y);
      end else begin
         e = pen_expected.pop_front();
         if (rsp_ch.moved) moved_seen++;
         compare_field("moved", e.moved, rsp_ch.moved);
         compare_field("pen_x", e.pen_x, longint'(rsp_ch.pen_x));
         compare_field("pen_y", e.pen_y, longint'(rsp_ch.pen_y));
         compare_field("nib_dx", e.nib_dx, longint'(rsp_ch.nib_dx));
         compare_field("nib_dy", e.nib_dy, longint'(rsp_ch.nib_dy));
         compare_field("pressure", e.pressure, longint'(rsp_ch.pressure));
      end
   endtask

   task automatic send_sample(bit op, int sx, int sy);
      int gap;
      gap = calm ? 0 : ($urandom_range(0, 99) < 35 ? $urandom_range(1, 5) : 0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.sample_x  <= sx;
      req_ch.sample_y  <= sy;
      do @(posedge clock); while (!req_ch.ready);
      pen_expected.push_back(smooth_step(op, sx, sy));
      samples_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pen_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [mdps_pkg::CSR_IDX_W-1:0] idx, longint v, longint mask,
                            ref longint shadow);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= mdps_pkg::CSR_DATA_W'(v);
      @(posedge clock);
      shadow = v & mask;
   endtask

   task automatic set_config(longint m, longint d, longint f, longint axv, longint ayv,
                             longint w, longint wr);
      drain();
      write_reg(mdps_pkg::CSR_MASS, m, 'h1ffff, mass_q);
      write_reg(mdps_pkg::CSR_DRAG, d, 'h1ffff, drag_q);
      write_reg(mdps_pkg::CSR_FIXED_ANGLE, f, 1, fixed_dir);
      write_reg(mdps_pkg::CSR_ANGLE_X, axv & 'h3ffff, 'h3ffff, dir_x);
      write_reg(mdps_pkg::CSR_ANGLE_Y, ayv & 'h3ffff, 'h3ffff, dir_y);
      write_reg(mdps_pkg::CSR_NIB_WIDTH, w, 'hffffff, nib_w);
      write_reg(mdps_pkg::CSR_WIDTH_RANGE, wr, 'h1ffff, w_range);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_config();
      set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536),
                 $urandom_range(0, 1),
                 $urandom, $urandom,
                 $urandom_range(0, 1) ? $urandom_range(0, 16777215) : $urandom_range(0, 400000),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536));
   endtask

   task automatic random_stroke(int moves);
      int x, y, step;
      x = $urandom_range(0, 7) == 0 ? $urandom
                                    : int'($signed($urandom) >>> $urandom_range(0, 8));
      y = $urandom_range(0, 7) == 0 ? $urandom
                                    : int'($signed($urandom) >>> $urandom_range(0, 8));
      send_sample(OP_START, x, y);
      for (int i = 0; i < moves; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_sample($urandom_range(0, 1), $urandom, $urandom);
         end else begin
            step = $urandom_range(4, 31);
            x = x + ($signed($urandom) >>> step);
            y = y + ($signed($urandom) >>> step);
            send_sample(OP_MOVE, x, y);
         end
      end
   endtask

   task automatic test_directed();
      calm = 1'b1;
      send_sample(OP_MOVE, 0, 0);
      send_sample(OP_START, 32'h7fffffff, 32'h7fffffff);
      send_sample(OP_MOVE, 32'h80000000, 32'h80000000);
      send_sample(OP_MOVE, 32'h80000000, 32'h80000000);
      send_sample(OP_MOVE, 32'h7fffffff, 32'h80000000);
      send_sample(OP_START, 0, 0);
      send_sample(OP_MOVE, 5, -3);
      send_sample(OP_MOVE, 1 << 24, -(1 << 23));
      send_sample(OP_MOVE, 1 << 24, -(1 << 23));
      send_sample(OP_START, -1, -1);
      send_sample(OP_MOVE, 32'h7fffffff, 32'h7fffffff);
      set_config(65536, 65536, 0, -65536, 65536, 16777215, 65536);
      send_sample(OP_START, 0, 0);
      send_sample(OP_MOVE, 200, 0);
      send_sample(OP_MOVE, 200, 0);
      send_sample(OP_MOVE, 0, 3000);
      send_sample(OP_MOVE, 1 << 26, -(1 << 26));
      send_sample(OP_MOVE, -(1 << 20), 1 << 22);
      set_config(0, 0, 1, 65536, -65536, 0, 0);
      send_sample(OP_START, 100, 100);
      send_sample(OP_MOVE, 1 << 22, 1 << 21);
      send_sample(OP_MOVE, -(1 << 22), 1 << 21);
      set_config(131071, 131071, 0, 'h3ffff, 'h20000, 16777215, 131071);
      send_sample(OP_START, 0, 0);
      send_sample(OP_MOVE, 1 << 25, 1 << 24);
      send_sample(OP_MOVE, -(1 << 25), 0);
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      random_stroke(12);
      drain();
   endtask

   task automatic test_calm_stretch();
      calm = 1'b1;
      random_stroke(60);
      calm = 1'b0;
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 8; p++) begin
         if (p == 0) set_config(mdps_pkg::RST_MASS, mdps_pkg::RST_DRAG,
                                mdps_pkg::RST_FIXED_ANGLE, mdps_pkg::RST_ANGLE_X,
                                mdps_pkg::RST_ANGLE_Y, mdps_pkg::RST_NIB_WIDTH,
                                mdps_pkg::RST_WIDTH_RANGE);
         else random_config();
         while (samples_sent < 100 + 230 * (p + 1)) begin
            random_stroke($urandom_range(3, 30));
            if ($urandom_range(0, 9) == 0) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (pen_expected.size() != 0) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      errors = 0;
      samples_sent = 0;
      beats_seen = 0;
      moved_seen = 0;
      calm = 1'b0;
      hold_req = 1'b0;
      hold_cnt = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_START;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
      mass_q = mdps_pkg::RST_MASS; drag_q = mdps_pkg::RST_DRAG;
      fixed_dir = mdps_pkg::RST_FIXED_ANGLE;
      dir_x = mdps_pkg::RST_ANGLE_X & 'h3ffff; dir_y = mdps_pkg::RST_ANGLE_Y & 'h3ffff;
      nib_w = mdps_pkg::RST_NIB_WIDTH; w_range = mdps_pkg::RST_WIDTH_RANGE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_calm_stretch();
      test_random_phases();
      drain();
      $display("tb: %0d samples sent, %0d beats checked, %0d with pen motion",
               samples_sent, beats_seen, moved_seen);
      $display("tb: corner settings, a long receiver hold-off, a no-idle stroke, 8 random phases");
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/mdps_pkg.sv
hdl/mdps_if.sv
hdl/mdps_mul.sv
hdl/mdps_div.sv
hdl/mdps_sqrt.sv
hdl/mass_drag_pointer_smoother_unit.sv
sim/tb.sv
